/* src/abm_pkg.sv */
// ----------------------------------------------------------------------------
// abm_pkg
// Request codes, status codes, controller states and the update flags shared
// by the allocation bitmap modules.
// ----------------------------------------------------------------------------
`default_nettype none

package abm_pkg;

  localparam int          REQ_W     = 3;
  localparam int          STATUS_W  = 2;
  localparam int          OFFSET_W  = 32;
  localparam int          BYTE_IDX_W = 7;
  localparam int          BYTE_W    = 8;
  localparam int          FREE_W    = 10;
  localparam int          COUNT_W   = 11;
  localparam logic [7:0]  BYTE_ONES = 8'hff;

  typedef enum logic [REQ_W-1:0] {
    REQ_TEST      = 3'd0,
    REQ_SET       = 3'd1,
    REQ_CLEAR     = 3'd2,
    REQ_FIND      = 3'd3,
    REQ_CLEAR_ALL = 3'd4,
    REQ_LOAD      = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_ALREADY    = 2'd1,
    ST_NOT_SET    = 2'd2,
    ST_NONE_FREE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_MOD,
    S_SUM,
    S_FCHK,
    S_FWORD,
    S_CLR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    was;
    status_e status;
    logic    wr_en;
  } upd_t;

endpackage

`default_nettype wire

/* src/allocation_bitmap.sv */
// ----------------------------------------------------------------------------
// allocation_bitmap
// Allocation bitmap with a running set-bit count. The map lives in a word
// memory; a second memory holds one full flag per map word for the
// find-first-zero search.
// ----------------------------------------------------------------------------
//
//   channel  handshake              payload
//   in       in_valid_i/in_stall_o   req_type_i, bit_offset_i, byte_index_i,
//                                    byte_value_i
//   out      out_valid_o/out_stall_i status_o, bit_was_set_o, free_index_o,
//                                    ones_count_o, map_full_o
//
// One request at a time. Test: word read, result. Set, clear, load byte:
// word read, write back, full-flag write back, result; the write backs are
// skipped when the bit is already in the wanted state. Find free: flag words
// are scanned up to the first non-full one (the first, at the default size,
// which has a single flag word), then its map word is read; a full map goes
// straight to the result. Clear all: each word in turn. After reset a clearing
// pass (one word a cycle) runs before any request is taken. A stalled result
// holds in the output register while the next request is already taken.
// ----------------------------------------------------------------------------
`default_nettype none

module allocation_bitmap #(
  parameter int BITMAP_BITS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [abm_pkg::REQ_W-1:0]          req_type_i,
  input  logic [abm_pkg::OFFSET_W-1:0]       bit_offset_i,
  input  logic [abm_pkg::BYTE_IDX_W-1:0]     byte_index_i,
  input  logic [abm_pkg::BYTE_W-1:0]         byte_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [abm_pkg::STATUS_W-1:0]       status_o,
  output logic                               bit_was_set_o,
  output logic [abm_pkg::FREE_W-1:0]         free_index_o,
  output logic [abm_pkg::COUNT_W-1:0]        ones_count_o,
  output logic                               map_full_o
);

  localparam int LOG2B  = $clog2(BITMAP_BITS);
  localparam int CNT_W  = LOG2B + 1;
  localparam int WORD_W = (BITMAP_BITS < 32) ? BITMAP_BITS : 32;
  localparam int LOG2W  = $clog2(WORD_W);
  localparam int NW     = BITMAP_BITS / WORD_W;
  localparam int AW     = (NW > 1) ? $clog2(NW) : 1;
  localparam int SUM_W  = (NW < 32) ? NW : 32;
  localparam int LOG2S  = $clog2(SUM_W);
  localparam int SBW    = (LOG2S > 0) ? LOG2S : 1;
  localparam int NS     = NW / SUM_W;
  localparam int SAW    = (NS > 1) ? $clog2(NS) : 1;

  function automatic logic [LOG2W-1:0] ffz_word(input logic [WORD_W-1:0] v);
    logic [LOG2W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!v[i]) r = LOG2W'(i);
    end
    return r;
  endfunction

  function automatic logic [SBW-1:0] ffz_sum(input logic [SUM_W-1:0] v);
    logic [SBW-1:0] r;
    r = '0;
    for (int i = SUM_W - 1; i >= 0; i--) begin
      if (!v[i]) r = SBW'(i);
    end
    return r;
  endfunction

  abm_pkg::state_e state_q, state_d;

  abm_pkg::req_e       req_q;
  logic [LOG2B-1:0]    off_q;
  logic [7:0]          bval_q;
  logic [CNT_W-1:0]    count_q;
  abm_pkg::status_e    res_status_q;
  logic                res_was_q;
  logic [LOG2B-1:0]    res_free_q;
  logic                full_q;
  logic [SAW-1:0]      scan_q;
  logic [AW-1:0]       fword_q;
  logic [AW-1:0]       clr_q;

  logic                               out_valid_q, out_valid_d;
  abm_pkg::status_e                   out_status_q;
  logic                               out_was_q;
  logic [abm_pkg::FREE_W-1:0]         out_free_q;
  logic [abm_pkg::COUNT_W-1:0]        out_count_q;
  logic                               out_full_q;

  logic [WORD_W-1:0] dmem [NW];
  logic [WORD_W-1:0] dmem_rdata_q;
  logic              dmem_we, dmem_re;
  logic [AW-1:0]     dmem_addr;
  logic [WORD_W-1:0] dmem_wdata;

  logic [SUM_W-1:0]  smem [NS];
  logic [SUM_W-1:0]  smem_rdata_q;
  logic              smem_we, smem_re;
  logic [SAW-1:0]    smem_addr;
  logic [SUM_W-1:0]  smem_wdata;

  abm_pkg::req_e     req_in;
  logic [LOG2B+9:0]  boff_ext;
  logic [LOG2B-1:0]  in_off;
  logic [AW-1:0]     in_waddr;
  logic [AW-1:0]     waddr_q;
  logic [SAW-1:0]    saddr_q;
  logic [SBW-1:0]    sbit_q;
  logic              count_full;
  logic              sum_has_free;
  logic [AW-1:0]     fword_nx;
  logic              clr_last;
  logic              clr_in_sum;
  logic              out_free;
  logic              resp_fire;
  logic [SUM_W-1:0]  sum_upd;

  logic [WORD_W-1:0] new_word;
  logic [CNT_W-1:0]  new_count;
  abm_pkg::upd_t     upd;

  assign req_in       = abm_pkg::req_e'(req_type_i);
  assign boff_ext     = (LOG2B + 10)'({byte_index_i, 3'b000});
  assign in_off       = (req_in == abm_pkg::REQ_LOAD) ? boff_ext[LOG2B-1:0]
                                                       : bit_offset_i[LOG2B-1:0];
  assign in_waddr     = AW'(in_off >> LOG2W);
  assign waddr_q      = AW'(off_q >> LOG2W);
  assign saddr_q      = SAW'(waddr_q >> LOG2S);
  assign sbit_q       = SBW'(waddr_q) & SBW'(SUM_W - 1);
  assign count_full   = (count_q == CNT_W'(BITMAP_BITS));
  assign sum_has_free = ~&smem_rdata_q;
  assign fword_nx     = (AW'(scan_q) << LOG2S) | AW'(ffz_sum(smem_rdata_q));
  assign clr_last     = (clr_q == AW'(NW - 1));
  assign clr_in_sum   = ({1'b0, clr_q} < (AW + 1)'(NS));
  assign out_free     = !out_valid_q || !out_stall_i;
  assign resp_fire    = (state_q == abm_pkg::S_RESP) && out_free;
  assign out_valid_d  = (out_valid_q && out_stall_i) || resp_fire;
  assign in_stall_o   = (state_q != abm_pkg::S_IDLE);

  always_comb begin
    sum_upd         = smem_rdata_q;
    sum_upd[sbit_q] = full_q;
  end

  abm_update #(
    .WORD_W (WORD_W),
    .CNT_W  (CNT_W)
  ) u_update (
    .req_i   (req_q),
    .word_i  (dmem_rdata_q),
    .sel_i   (off_q[LOG2W-1:0]),
    .byte_i  (bval_q),
    .count_i (count_q),
    .word_o  (new_word),
    .count_o (new_count),
    .upd_o   (upd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      abm_pkg::S_INIT: begin
        if (clr_last) state_d = abm_pkg::S_IDLE;
      end
      abm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (req_in)
            abm_pkg::REQ_TEST,
            abm_pkg::REQ_SET,
            abm_pkg::REQ_CLEAR,
            abm_pkg::REQ_LOAD:      state_d = abm_pkg::S_MOD;
            abm_pkg::REQ_FIND:      state_d = count_full ? abm_pkg::S_RESP : abm_pkg::S_FCHK;
            abm_pkg::REQ_CLEAR_ALL: state_d = abm_pkg::S_CLR;
            default:                state_d = abm_pkg::S_RESP;
          endcase
        end
      end
      abm_pkg::S_MOD: begin
        state_d = upd.wr_en ? abm_pkg::S_SUM : abm_pkg::S_RESP;
      end
      abm_pkg::S_SUM: begin
        state_d = abm_pkg::S_RESP;
      end
      abm_pkg::S_FCHK: begin
        if (sum_has_free) state_d = abm_pkg::S_FWORD;
      end
      abm_pkg::S_FWORD: begin
        state_d = abm_pkg::S_RESP;
      end
      abm_pkg::S_CLR: begin
        if (clr_last) state_d = abm_pkg::S_RESP;
      end
      abm_pkg::S_RESP: begin
        if (out_free) state_d = abm_pkg::S_IDLE;
      end
      default: begin
        state_d = abm_pkg::S_INIT;
      end
    endcase
  end

  always_comb begin
    dmem_we    = 1'b0;
    dmem_re    = 1'b0;
    dmem_addr  = waddr_q;
    dmem_wdata = new_word;
    smem_we    = 1'b0;
    smem_re    = 1'b0;
    smem_addr  = saddr_q;
    smem_wdata = sum_upd;
    case (state_q)
      abm_pkg::S_INIT,
      abm_pkg::S_CLR: begin
        dmem_we    = 1'b1;
        dmem_addr  = clr_q;
        dmem_wdata = '0;
        smem_we    = clr_in_sum;
        smem_addr  = SAW'(clr_q);
        smem_wdata = '0;
      end
      abm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (req_in)
            abm_pkg::REQ_TEST,
            abm_pkg::REQ_SET,
            abm_pkg::REQ_CLEAR,
            abm_pkg::REQ_LOAD: begin
              dmem_re   = 1'b1;
              dmem_addr = in_waddr;
            end
            abm_pkg::REQ_FIND: begin
              smem_re   = !count_full;
              smem_addr = '0;
            end
            default: begin
              dmem_re = 1'b0;
            end
          endcase
        end
      end
      abm_pkg::S_MOD: begin
        dmem_we = upd.wr_en;
        smem_re = upd.wr_en;
      end
      abm_pkg::S_SUM: begin
        smem_we = 1'b1;
      end
      abm_pkg::S_FCHK: begin
        if (sum_has_free) begin
          dmem_re   = 1'b1;
          dmem_addr = fword_nx;
        end else begin
          smem_re   = 1'b1;
          smem_addr = scan_q + SAW'(1);
        end
      end
      default: begin
        dmem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dmem_we) dmem[dmem_addr] <= dmem_wdata;
    if (dmem_re) dmem_rdata_q <= dmem[dmem_addr];
  end

  always_ff @(posedge clk_i) begin
    if (smem_we) smem[smem_addr] <= smem_wdata;
    if (smem_re) smem_rdata_q <= smem[smem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abm_pkg::S_INIT;
      count_q     <= '0;
      clr_q       <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      case (state_q)
        abm_pkg::S_INIT,
        abm_pkg::S_CLR: begin
          clr_q <= clr_q + AW'(1);
        end
        abm_pkg::S_IDLE: begin
          if (in_valid_i && req_in == abm_pkg::REQ_CLEAR_ALL) begin
            count_q <= '0;
            clr_q   <= '0;
          end
          if (in_valid_i && req_in == abm_pkg::REQ_FIND) scan_q <= '0;
        end
        abm_pkg::S_MOD: begin
          count_q <= new_count;
        end
        abm_pkg::S_FCHK: begin
          if (!sum_has_free) scan_q <= scan_q + SAW'(1);
        end
        default: begin
          count_q <= count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      abm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_q        <= req_in;
          off_q        <= in_off;
          bval_q       <= byte_value_i;
          res_was_q    <= 1'b0;
          res_free_q   <= '0;
          res_status_q <= (req_in == abm_pkg::REQ_FIND && count_full) ? abm_pkg::ST_NONE_FREE
                                                                     : abm_pkg::ST_OK;
        end
      end
      abm_pkg::S_MOD: begin
        res_status_q <= upd.status;
        res_was_q    <= upd.was;
        full_q       <= &new_word;
      end
      abm_pkg::S_FCHK: begin
        fword_q <= fword_nx;
      end
      abm_pkg::S_FWORD: begin
        res_free_q <= (LOG2B'(fword_q) << LOG2W) | LOG2B'(ffz_word(dmem_rdata_q));
      end
      default: begin
        full_q <= full_q;
      end
    endcase
    if (resp_fire) begin
      out_status_q <= res_status_q;
      out_was_q    <= res_was_q;
      out_free_q   <= abm_pkg::FREE_W'(res_free_q);
      out_count_q  <= abm_pkg::COUNT_W'(count_q);
      out_full_q   <= count_full;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign bit_was_set_o = out_was_q;
  assign free_index_o  = out_free_q;
  assign ones_count_o  = out_count_q;
  assign map_full_o    = out_full_q;

endmodule

`default_nettype wire

/* src/abm_update.sv */
// ----------------------------------------------------------------------------
// abm_update
// Modify step of the read-modify-write: applies a test, set, clear or byte
// load to one map word and works out the new set-bit count.
// ----------------------------------------------------------------------------
`default_nettype none

module abm_update #(
  parameter int WORD_W = 32,
  parameter int CNT_W  = 11
) (
  input  abm_pkg::req_e               req_i,
  input  logic [WORD_W-1:0]           word_i,
  input  logic [$clog2(WORD_W)-1:0]   sel_i,
  input  logic [abm_pkg::BYTE_W-1:0]  byte_i,
  input  logic [CNT_W-1:0]            count_i,
  output logic [WORD_W-1:0]           word_o,
  output logic [CNT_W-1:0]            count_o,
  output abm_pkg::upd_t               upd_o
);

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + 4'(v[k]);
    end
    return n;
  endfunction

  logic              was;
  logic [WORD_W-1:0] bit_mask;
  logic [WORD_W-1:0] lane_mask;
  logic [WORD_W-1:0] lane_data;
  logic [7:0]        old_byte;

  assign was       = word_i[sel_i];
  assign bit_mask  = WORD_W'(1) << sel_i;
  assign lane_mask = WORD_W'(abm_pkg::BYTE_ONES) << sel_i;
  assign lane_data = WORD_W'(byte_i) << sel_i;
  assign old_byte  = 8'(word_i >> sel_i);

  always_comb begin
    word_o        = word_i;
    count_o       = count_i;
    upd_o.was     = 1'b0;
    upd_o.status  = abm_pkg::ST_OK;
    upd_o.wr_en   = 1'b0;
    case (req_i)
      abm_pkg::REQ_TEST: begin
        upd_o.was = was;
      end
      abm_pkg::REQ_SET: begin
        upd_o.was = was;
        if (was) begin
          upd_o.status = abm_pkg::ST_ALREADY;
        end else begin
          word_o      = word_i | bit_mask;
          count_o     = count_i + CNT_W'(1);
          upd_o.wr_en = 1'b1;
        end
      end
      abm_pkg::REQ_CLEAR: begin
        upd_o.was = was;
        if (!was) begin
          upd_o.status = abm_pkg::ST_NOT_SET;
        end else begin
          word_o      = word_i & ~bit_mask;
          count_o     = count_i - CNT_W'(1);
          upd_o.wr_en = 1'b1;
        end
      end
      abm_pkg::REQ_LOAD: begin
        word_o      = (word_i & ~lane_mask) | lane_data;
        count_o     = count_i - CNT_W'(popcount8(old_byte)) + CNT_W'(popcount8(byte_i));
        upd_o.wr_en = 1'b1;
      end
      default: begin
        upd_o.wr_en = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/abm_chk.sv */
// ----------------------------------------------------------------------------
// abm_chk
// Port-level checks for the allocation bitmap, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module abm_chk #(
  parameter int BITMAP_BITS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               out_valid_o,
  input  logic                               out_stall_i,
  input  logic [abm_pkg::STATUS_W-1:0]       status_o,
  input  logic                               bit_was_set_o,
  input  logic [abm_pkg::FREE_W-1:0]         free_index_o,
  input  logic [abm_pkg::COUNT_W-1:0]        ones_count_o,
  input  logic                               map_full_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(free_index_o) && $stable(ones_count_o) && $stable(bit_was_set_o))
    else $error("stalled request result changed");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && map_full_o |-> ones_count_o == abm_pkg::COUNT_W'(BITMAP_BITS))
    else $error("full flag without full count");

  a_none_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == abm_pkg::ST_NONE_FREE |->
      map_full_o && free_index_o == '0 && !bit_was_set_o)
    else $error("none free on a map with space");

  a_already: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == abm_pkg::ST_ALREADY |-> bit_was_set_o)
    else $error("already set on a clear bit");

  a_not_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == abm_pkg::ST_NOT_SET |-> !bit_was_set_o)
    else $error("not set on a set bit");

endmodule

bind allocation_bitmap abm_chk #(.BITMAP_BITS(BITMAP_BITS)) u_abm_chk (.*);

`default_nettype wire

/* bench/tb_allocation_bitmap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_allocation_bitmap
// Self-checking bench for the allocation bitmap. A queue of requests feeds a
// clocked driver. Each accepted request is applied to a local bitmap model
// and the predicted result is queued. A clocked monitor compares every
// accepted result field by field. Stimulus: a short directed pass, then
// random traffic and rounds that fill the map to full and punch holes in it.
// Both channels idle at random, with one calm stretch and one long output
// hold-off that back-pressures the input.
// ----------------------------------------------------------------------------

module tb_allocation_bitmap;

  localparam int MAP_BITS      = 1024;
  localparam int MAP_BYTES     = MAP_BITS / 8;
  localparam int POS_W         = $clog2(MAP_BITS);
  localparam int IDLE_PCT      = 32;
  localparam int HOLD_CYCLES   = 300;
  localparam int STUCK_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 60;
  localparam int TOTAL_REQS    = 500;

  localparam logic [abm_pkg::REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [abm_pkg::REQ_W-1:0] REQ_SPARE_B = 3'd7;

  typedef struct packed {
    logic [abm_pkg::REQ_W-1:0]      kind;
    logic [abm_pkg::OFFSET_W-1:0]   offset;
    logic [abm_pkg::BYTE_IDX_W-1:0] byte_idx;
    logic [abm_pkg::BYTE_W-1:0]     byte_val;
  } alloc_req_t;

  typedef struct packed {
    abm_pkg::status_e               status;
    logic                           was;
    logic [abm_pkg::FREE_W-1:0]     free;
    logic [abm_pkg::COUNT_W-1:0]    count;
    logic                           full;
  } alloc_res_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  alloc_req_t drv_req   = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       out_stall = 1'b0;

  logic [abm_pkg::STATUS_W-1:0] status;
  logic                         bit_was_set;
  logic [abm_pkg::FREE_W-1:0]   free_index;
  logic [abm_pkg::COUNT_W-1:0]  ones_count;
  logic                         map_full;

  alloc_req_t pending_reqs[$];
  alloc_res_t expected_results[$];
  alloc_res_t oldest_result;

  logic [MAP_BITS-1:0] map_model = '0;
  int                  set_total = 0;

  logic calm         = 1'b0;
  logic squeeze_go   = 1'b0;
  logic squeeze_done = 1'b0;
  int   hold_left    = 0;
  int   mismatches   = 0;
  int   stuck_cycles = 0;
  int   reqs_queued  = 0;

  always #2 clk = ~clk;

  allocation_bitmap #(
    .BITMAP_BITS(MAP_BITS)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .req_type_i   (drv_req.kind),
    .bit_offset_i (drv_req.offset),
    .byte_index_i (drv_req.byte_idx),
    .byte_value_i (drv_req.byte_val),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .bit_was_set_o(bit_was_set),
    .free_index_o (free_index),
    .ones_count_o (ones_count),
    .map_full_o   (map_full)
  );

  function automatic alloc_res_t apply_request(input alloc_req_t r);
    alloc_res_t       res;
    logic [POS_W-1:0] pos;
    int               base;
    logic [7:0]       old_byte;
    logic             found;
    res        = '0;
    res.status = abm_pkg::ST_OK;
    pos        = r.offset[POS_W-1:0];
    base       = (int'(r.byte_idx) % MAP_BYTES) * 8;
    found      = 1'b0;
    case (r.kind)
      abm_pkg::REQ_TEST: begin
        res.was = map_model[pos];
      end
      abm_pkg::REQ_SET: begin
        res.was = map_model[pos];
        if (res.was) begin
          res.status = abm_pkg::ST_ALREADY;
        end else begin
          map_model[pos] = 1'b1;
          set_total++;
        end
      end
      abm_pkg::REQ_CLEAR: begin
        res.was = map_model[pos];
        if (!res.was) begin
          res.status = abm_pkg::ST_NOT_SET;
        end else begin
          map_model[pos] = 1'b0;
          set_total--;
        end
      end
      abm_pkg::REQ_FIND: begin
        for (int i = 0; i < MAP_BITS; i++) begin
          if (!found && !map_model[i]) begin
            res.free = abm_pkg::FREE_W'(i);
            found    = 1'b1;
          end
        end
        if (!found) res.status = abm_pkg::ST_NONE_FREE;
      end
      abm_pkg::REQ_CLEAR_ALL: begin
        map_model = '0;
        set_total = 0;
      end
      abm_pkg::REQ_LOAD: begin
        old_byte  = map_model[base +: 8];
        set_total = set_total - $countones(old_byte) + $countones(r.byte_val);
        map_model[base +: 8] = r.byte_val;
      end
      default: ;
    endcase
    res.count = abm_pkg::COUNT_W'(set_total);
    res.full  = (set_total == MAP_BITS);
    return res;
  endfunction

  task automatic push_req(input logic [abm_pkg::REQ_W-1:0] kind,
                          input logic [abm_pkg::OFFSET_W-1:0] offset,
                          input int unsigned bidx, input int unsigned bval);
    alloc_req_t r;
    r.kind     = kind;
    r.offset   = offset;
    r.byte_idx = abm_pkg::BYTE_IDX_W'(bidx);
    r.byte_val = abm_pkg::BYTE_W'(bval);
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  task automatic push_noise(input int n);
    logic [abm_pkg::OFFSET_W-1:0] off;
    logic [abm_pkg::REQ_W-1:0]    kind;
    int                           pick;
    for (int k = 0; k < n; k++) begin
      off = $urandom();
      if ($urandom_range(0, 1) == 0) off[POS_W-1:0] = POS_W'($urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 25)      kind = abm_pkg::REQ_SET;
      else if (pick < 45) kind = abm_pkg::REQ_CLEAR;
      else if (pick < 60) kind = abm_pkg::REQ_TEST;
      else if (pick < 75) kind = abm_pkg::REQ_FIND;
      else if (pick < 88) kind = abm_pkg::REQ_LOAD;
      else if (pick < 91) kind = abm_pkg::REQ_CLEAR_ALL;
      else if (pick < 95) kind = REQ_SPARE_A;
      else                kind = REQ_SPARE_B;
      push_req(kind, off, $urandom(), $urandom());
    end
  endtask

  // fill the map to full, then open a few holes and close them again
  task automatic push_fill_round();
    logic [POS_W-1:0]             holes[4];
    logic [abm_pkg::OFFSET_W-1:0] off;
    int                           first;
    int                           n_holes;
    int                           b;
    push_req(abm_pkg::REQ_CLEAR_ALL, $urandom(), $urandom(), $urandom());
    first = $urandom_range(0, MAP_BYTES - 1);
    for (int k = 0; k < MAP_BYTES; k++) begin
      b = (first + k) % MAP_BYTES;
      if ($urandom_range(0, 3) == 0) push_req(abm_pkg::REQ_LOAD, $urandom(), b, $urandom());
      if ($urandom_range(0, 15) == 0) begin
        push_req(abm_pkg::REQ_FIND, $urandom(), $urandom(), $urandom());
      end
      push_req(abm_pkg::REQ_LOAD, $urandom(), b, 32'(abm_pkg::BYTE_ONES));
    end
    push_req(abm_pkg::REQ_FIND, $urandom(), $urandom(), $urandom());
    push_req(abm_pkg::REQ_SET, $urandom(), $urandom(), $urandom());
    push_req(abm_pkg::REQ_TEST, $urandom(), $urandom(), $urandom());
    n_holes = $urandom_range(1, 4);
    for (int k = 0; k < n_holes; k++) begin
      off      = $urandom();
      holes[k] = off[POS_W-1:0];
      push_req(abm_pkg::REQ_CLEAR, off, $urandom(), $urandom());
    end
    push_req(abm_pkg::REQ_FIND, $urandom(), $urandom(), $urandom());
    off = $urandom();
    off[POS_W-1:0] = holes[0];
    push_req(abm_pkg::REQ_CLEAR, off, $urandom(), $urandom());
    for (int k = 0; k < n_holes; k++) begin
      off = $urandom();
      off[POS_W-1:0] = holes[k];
      push_req(abm_pkg::REQ_SET, off, $urandom(), $urandom());
      push_req(abm_pkg::REQ_FIND, $urandom(), $urandom(), $urandom());
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(apply_request(drv_req));
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 &&
            (calm || squeeze_go || $urandom_range(0, 99) >= IDLE_PCT)) begin
          drv_req  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %0d count %0d",
                   $time, status, ones_count);
          mismatches++;
        end else begin
          oldest_result = expected_results.pop_front();
          check_field("status", oldest_result.status, status);
          check_field("bit_was_set", oldest_result.was, bit_was_set);
          check_field("free_index", oldest_result.free, free_index);
          check_field("ones_count", oldest_result.count, ones_count);
          check_field("map_full", oldest_result.full, map_full);
        end
      end
      if (squeeze_go && !squeeze_done && hold_left == 0) begin
        hold_left    = HOLD_CYCLES;
        squeeze_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    push_req(abm_pkg::REQ_TEST, 32'h0000_0000, 0, 0);
    push_req(abm_pkg::REQ_TEST, 32'hffff_ffff, 'h7f, 'hff);
    push_req(abm_pkg::REQ_SET, 32'h0000_0000, $urandom(), $urandom());
    push_req(abm_pkg::REQ_SET, 32'h8000_0000, $urandom(), $urandom());
    push_req(abm_pkg::REQ_CLEAR, 32'h0000_0005, $urandom(), $urandom());
    push_req(abm_pkg::REQ_SET, 32'hffff_ffff, $urandom(), $urandom());
    push_req(abm_pkg::REQ_FIND, $urandom(), $urandom(), $urandom());
    push_req(abm_pkg::REQ_LOAD, $urandom(), 0, 32'(abm_pkg::BYTE_ONES));
    push_req(abm_pkg::REQ_FIND, $urandom(), $urandom(), $urandom());
    push_req(abm_pkg::REQ_LOAD, $urandom(), 'h7f, 'h7f);
    push_req(abm_pkg::REQ_CLEAR, 32'h0000_03ff, $urandom(), $urandom());
    push_req(abm_pkg::REQ_CLEAR, 32'h0000_0003, $urandom(), $urandom());
    push_req(abm_pkg::REQ_FIND, $urandom(), $urandom(), $urandom());
    push_req(REQ_SPARE_A, $urandom(), $urandom(), $urandom());
    push_req(REQ_SPARE_B, $urandom(), $urandom(), $urandom());
    push_req(abm_pkg::REQ_LOAD, $urandom(), 0, 0);
    push_req(abm_pkg::REQ_CLEAR_ALL, $urandom(), $urandom(), $urandom());
    push_req(abm_pkg::REQ_FIND, $urandom(), $urandom(), $urandom());
    push_req(abm_pkg::REQ_TEST, 32'h0000_03ff, $urandom(), $urandom());

    push_noise(50);
    push_fill_round();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait_drained();
    calm = 1'b1;
    push_fill_round();
    push_noise(40);
    wait_drained();
    calm = 1'b0;

    // hold the output back while requests keep coming
    squeeze_go = 1'b1;
    push_noise(40);
    wait_drained();
    while (hold_left != 0) @(negedge clk);
    squeeze_go = 1'b0;

    if (reqs_queued < TOTAL_REQS) push_noise(TOTAL_REQS - reqs_queued);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
